// ===== hdl/dit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device ID table package
// Shared widths, request codes, defaults and the result status structure.
// ----------------------------------------------------------------------------
package dit_pkg;

  localparam int unsigned DefTableEntries = 128;

  localparam int unsigned IdWidth    = 64;
  localparam int unsigned StampWidth = 32;
  localparam int unsigned ReqWidth   = 2;

  localparam logic [StampWidth-1:0] ExpireReset = 32'd60;

  typedef enum logic [ReqWidth-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_SWEEP  = 2'd2
  } req_code_t;

  typedef struct packed {
    logic valid;
    logic found;
    logic add_failed;
  } result_t;

endpackage

// ===== hdl/dit_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device ID table channel interfaces
// Request and response channels with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface dit_req_if;
  logic                               valid;
  logic                               ready;
  logic [dit_pkg::ReqWidth-1:0]       req_type;
  logic [dit_pkg::IdWidth-1:0]        dev_id;
  logic [dit_pkg::StampWidth-1:0]     now;

  modport source (output valid, output req_type, output dev_id, output now,
                  input ready);
  modport sink (input valid, input req_type, input dev_id, input now,
                output ready);
endinterface

interface dit_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic add_failed;

  modport source (output valid, output found, output add_failed, input ready);
  modport sink (input valid, input found, input add_failed, output ready);
endinterface

// ===== hdl/dit_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
  input  logic [Width-1:0]                          wr_data,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
  output logic [Width-1:0]                          rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/dit_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device ID table scan engine
// Clears the identifier store after reset, then scans both memories one
// entry per cycle for each request, writing back adds and expirations.
// ----------------------------------------------------------------------------
module dit_engine #(
  parameter int unsigned TableEntries = dit_pkg::DefTableEntries,
  localparam int unsigned Aw = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dit_pkg::ReqWidth-1:0]      req_type,
  input  logic [dit_pkg::IdWidth-1:0]       dev_id,
  input  logic [dit_pkg::StampWidth-1:0]    now,
  input  logic [dit_pkg::StampWidth-1:0]    expiry_limit,
  output logic                              idle,
  output logic [Aw-1:0]                     rd_addr,
  input  logic [dit_pkg::IdWidth-1:0]       rd_id,
  input  logic [dit_pkg::StampWidth-1:0]    rd_stamp,
  output logic                              id_we,
  output logic                              stamp_we,
  output logic [Aw-1:0]                     wr_addr,
  output logic [dit_pkg::IdWidth-1:0]       wr_id,
  output logic [dit_pkg::StampWidth-1:0]    wr_stamp,
  output dit_pkg::result_t                  result,
  input  logic                              result_take
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  localparam logic [Aw:0] EntriesCnt = (Aw + 1)'(TableEntries);
  localparam logic [Aw:0] LastCnt    = (Aw + 1)'(TableEntries - 1);

  state_t                          state;
  logic [Aw:0]                     cnt;
  logic                            p_valid;
  logic [Aw-1:0]                   p_addr;
  logic [dit_pkg::ReqWidth-1:0]    req_q;
  logic [dit_pkg::IdWidth-1:0]     id_q;
  logic [dit_pkg::StampWidth-1:0]  now_q;
  logic                            placed;
  logic                            found_acc;

  logic                            cnt_lt_n;
  logic                            entry_used;
  logic [dit_pkg::StampWidth-1:0]  age;
  logic                            expired;
  logic                            id_hit;
  logic                            free_hit;
  logic                            is_lookup;
  logic                            is_add;
  logic                            is_sweep;

  assign cnt_lt_n   = (cnt < EntriesCnt);
  assign rd_addr    = cnt[Aw-1:0];
  assign entry_used = (rd_id != '0);
  assign age        = now_q - rd_stamp;
  assign expired    = entry_used && (age >= expiry_limit);
  assign id_hit     = p_valid && (rd_id == id_q);
  assign free_hit   = p_valid && !entry_used && !placed;
  assign is_lookup  = (req_q == dit_pkg::REQ_LOOKUP);
  assign is_add     = (req_q == dit_pkg::REQ_ADD);
  assign is_sweep   = (req_q == dit_pkg::REQ_SWEEP);

  assign idle              = (state == ST_IDLE);
  assign result.valid      = (state == ST_RESULT);
  assign result.found      = is_lookup && found_acc;
  assign result.add_failed = is_add && !placed;

  always_comb begin
    id_we    = 1'b0;
    stamp_we = 1'b0;
    wr_addr  = p_addr;
    wr_id    = '0;
    wr_stamp = now_q;
    unique case (state)
      ST_CLEAR: begin
        id_we   = 1'b1;
        wr_addr = cnt[Aw-1:0];
      end
      ST_SCAN: begin
        if (is_add && free_hit) begin
          id_we    = 1'b1;
          stamp_we = 1'b1;
          wr_id    = id_q;
        end else if (is_sweep && p_valid && expired) begin
          id_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      p_valid   <= 1'b0;
      placed    <= 1'b0;
      found_acc <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (cnt == LastCnt) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state     <= ST_SCAN;
            cnt       <= '0;
            placed    <= 1'b0;
            found_acc <= 1'b0;
          end
        end
        ST_SCAN: begin
          p_valid <= cnt_lt_n;
          if (cnt_lt_n) begin
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_RESULT;
          end
          if (id_hit) begin
            found_acc <= 1'b1;
          end
          if (is_add && free_hit) begin
            placed <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (result_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= cnt[Aw-1:0];
    if (idle && start) begin
      req_q <= req_type;
      id_q  <= dev_id;
      now_q <= now;
    end
  end

endmodule

// ===== hdl/device_id_table_with_aging.sv =====
`timescale 1ns / 1ps
// Requests are handled one at a time: a new request is accepted only once the
// previous result has passed into the response register. Each request is
// served by a one-entry-per-cycle scan of the identifier and stamp memories.
// Reset: after rst falls, a clearing pass zeroes the identifier memory; no
// request is accepted until it ends. The expiry limit resets to 60.
// ----------------------------------------------------------------------------
// Device ID table with aging
// Lookup, add and expiry sweep over a memory-based table of identifiers.
// ----------------------------------------------------------------------------
module device_id_table_with_aging #(
  parameter int unsigned TableEntries = dit_pkg::DefTableEntries
) (
  input  logic                           clk,
  input  logic                           rst,
  dit_req_if.sink                        req,
  dit_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [dit_pkg::StampWidth-1:0] cfg_wdata
);

  localparam int unsigned Aw = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  logic [dit_pkg::StampWidth-1:0] expiry_limit;
  logic                           eng_idle;
  logic                           start;
  logic [Aw-1:0]                  rd_addr;
  logic [Aw-1:0]                  wr_addr;
  logic [dit_pkg::IdWidth-1:0]    rd_id;
  logic [dit_pkg::IdWidth-1:0]    wr_id;
  logic [dit_pkg::StampWidth-1:0] rd_stamp;
  logic [dit_pkg::StampWidth-1:0] wr_stamp;
  logic                           id_we;
  logic                           stamp_we;
  dit_pkg::result_t               result;
  logic                           result_take;
  logic                           out_valid;
  logic                           out_found;
  logic                           out_add_failed;

  assign req.ready   = eng_idle;
  assign start       = req.valid && eng_idle;
  assign result_take = !out_valid || rsp.ready;

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.add_failed = out_add_failed;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_limit <= dit_pkg::ExpireReset;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        expiry_limit <= cfg_wdata;
      end
      if (result_take) begin
        out_valid <= result.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_take && result.valid) begin
      out_found      <= result.found;
      out_add_failed <= result.add_failed;
    end
  end

  dit_engine #(
    .TableEntries(TableEntries)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req.req_type),
    .dev_id       (req.dev_id),
    .now          (req.now),
    .expiry_limit (expiry_limit),
    .idle         (eng_idle),
    .rd_addr      (rd_addr),
    .rd_id        (rd_id),
    .rd_stamp     (rd_stamp),
    .id_we        (id_we),
    .stamp_we     (stamp_we),
    .wr_addr      (wr_addr),
    .wr_id        (wr_id),
    .wr_stamp     (wr_stamp),
    .result       (result),
    .result_take  (result_take)
  );

  dit_ram #(
    .Width(dit_pkg::IdWidth),
    .Depth(TableEntries)
  ) u_id_ram (
    .clk     (clk),
    .wr_en   (id_we),
    .wr_addr (wr_addr),
    .wr_data (wr_id),
    .rd_addr (rd_addr),
    .rd_data (rd_id)
  );

  dit_ram #(
    .Width(dit_pkg::StampWidth),
    .Depth(TableEntries)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (stamp_we),
    .wr_addr (wr_addr),
    .wr_data (wr_stamp),
    .rd_addr (rd_addr),
    .rd_data (rd_stamp)
  );

endmodule

// ===== hdl/dit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device ID table port checker
// Checks the port behavior of the table over time; bound to the top level.
// ----------------------------------------------------------------------------
module dit_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic found,
  input logic add_failed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(add_failed))
    else $error("Response changed while stalled.");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && add_failed))
    else $error("Response has both found and add_failed set.");

  a_clear_pass: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("Request accepted during the clearing pass.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Request accepted while another is in progress.");

endmodule

bind device_id_table_with_aging dit_checker u_dit_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .found      (rsp.found),
  .add_failed (rsp.add_failed)
);

// ===== test/device_id_table_with_aging_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device ID table with aging testbench
// Sends lookup, add, expiry sweep and unused-code requests under several
// expiry settings, with random idle bursts on the request side and stall
// bursts on the response side. A table model in the testbench predicts each
// response, and every response transfer is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module device_id_table_with_aging_tb;

  localparam int unsigned TABLE_ENTRIES = dit_pkg::DefTableEntries;
  localparam int unsigned LATENCY = TABLE_ENTRIES + 3;
  localparam int unsigned CYCLE_LIMIT = 1_200_000;
  localparam logic [dit_pkg::ReqWidth-1:0] REQ_UNUSED = 2'd3;
  localparam logic [dit_pkg::IdWidth-1:0] ID_ONES = '1;
  localparam logic [dit_pkg::StampWidth-1:0] TIME_ONES = '1;
  localparam logic [dit_pkg::IdWidth-1:0] ID_PATTERN = 64'hA5A5_5A5A_0F0F_F0F0;
  localparam logic [dit_pkg::IdWidth-1:0] ID_TOP_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic found;
    logic add_failed;
  } outcome_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [dit_pkg::StampWidth-1:0] cfg_wdata;

  dit_req_if req_ch();
  dit_rsp_if rsp_ch();

  logic [dit_pkg::IdWidth-1:0]    table_ids    [TABLE_ENTRIES];
  logic [dit_pkg::StampWidth-1:0] table_stamps [TABLE_ENTRIES];
  logic [dit_pkg::StampWidth-1:0] expire_setting;
  logic [dit_pkg::StampWidth-1:0] clock_now;
  outcome_t                       pending_outcomes [$];
  bit                             idle_en = 1'b1;
  int unsigned                    err_count = 0;
  int unsigned                    checked_count = 0;
  int unsigned                    cycle_count = 0;

  device_id_table_with_aging #(
    .TableEntries(TABLE_ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic outcome_t apply_request(logic [dit_pkg::ReqWidth-1:0] code,
                                             logic [dit_pkg::IdWidth-1:0] id,
                                             logic [dit_pkg::StampWidth-1:0] tnow);
    outcome_t                       res;
    bit                             placed;
    logic [dit_pkg::StampWidth-1:0] age;
    res = '0;
    placed = 1'b0;
    case (code)
      dit_pkg::REQ_LOOKUP: begin
        foreach (table_ids[i]) begin
          if (table_ids[i] == id) res.found = 1'b1;
        end
      end
      dit_pkg::REQ_ADD: begin
        foreach (table_ids[i]) begin
          if (!placed && table_ids[i] == '0) begin
            table_ids[i] = id;
            table_stamps[i] = tnow;
            placed = 1'b1;
          end
        end
        res.add_failed = !placed;
      end
      dit_pkg::REQ_SWEEP: begin
        foreach (table_ids[i]) begin
          if (table_ids[i] != '0) begin
            age = tnow - table_stamps[i];
            if (age >= expire_setting) table_ids[i] = '0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [dit_pkg::IdWidth-1:0] random_id();
    if ($urandom_range(0, 19) == 0) return '0;
    if ($urandom_range(0, 3) == 0) return {32'd0, $urandom};
    return {$urandom, $urandom};
  endfunction

  task automatic send_req(logic [dit_pkg::ReqWidth-1:0] code,
                          logic [dit_pkg::IdWidth-1:0] id,
                          logic [dit_pkg::StampWidth-1:0] tnow);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        while (pending_outcomes.size() != 0) @(posedge clk);
      end
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= code;
    req_ch.dev_id    <= id;
    req_ch.now       <= tnow;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_outcomes.push_back(apply_request(code, id, tnow));
  endtask

  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_expire(logic [dit_pkg::StampWidth-1:0] value);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    expire_setting = value;
  endtask

  task automatic test_empty_table();
    send_req(dit_pkg::REQ_LOOKUP, '0, '0);
    send_req(dit_pkg::REQ_LOOKUP, ID_ONES, TIME_ONES);
    send_req(REQ_UNUSED, ID_ONES, TIME_ONES);
    send_req(dit_pkg::REQ_SWEEP, ID_ONES, '0);
  endtask

  task automatic test_add_lookup();
    send_req(dit_pkg::REQ_ADD, ID_ONES, 32'd100);
    send_req(dit_pkg::REQ_LOOKUP, ID_ONES, '0);
    send_req(dit_pkg::REQ_ADD, '0, 32'd5);
    send_req(dit_pkg::REQ_ADD, 64'd1, TIME_ONES);
    send_req(dit_pkg::REQ_LOOKUP, 64'd1, '0);
    send_req(dit_pkg::REQ_LOOKUP, '0, '0);
    send_req(dit_pkg::REQ_ADD, ID_ONES, 32'd100);
  endtask

  task automatic test_expiry_boundary();
    send_req(dit_pkg::REQ_SWEEP, '0, 32'd159);
    send_req(dit_pkg::REQ_LOOKUP, ID_ONES, '0);
    send_req(dit_pkg::REQ_SWEEP, ID_ONES, 32'd160);
    send_req(dit_pkg::REQ_LOOKUP, ID_ONES, '0);
    send_req(dit_pkg::REQ_ADD, ID_PATTERN, 32'hFFFF_FFF0);
    send_req(dit_pkg::REQ_SWEEP, '0, 32'h0000_002B);
    send_req(dit_pkg::REQ_LOOKUP, ID_PATTERN, '0);
    send_req(dit_pkg::REQ_SWEEP, '0, 32'h0000_002C);
    send_req(dit_pkg::REQ_LOOKUP, ID_PATTERN, '0);
  endtask

  task automatic test_expire_extremes();
    write_expire('0);
    send_req(dit_pkg::REQ_ADD, ID_TOP_BIT, 32'd7);
    send_req(dit_pkg::REQ_SWEEP, '0, 32'd7);
    send_req(dit_pkg::REQ_LOOKUP, ID_TOP_BIT, '0);
    write_expire(TIME_ONES);
    send_req(dit_pkg::REQ_ADD, ID_PATTERN, '0);
    send_req(dit_pkg::REQ_SWEEP, '0, 32'hFFFF_FFFE);
    send_req(dit_pkg::REQ_SWEEP, '0, TIME_ONES);
    send_req(dit_pkg::REQ_LOOKUP, ID_PATTERN, '0);
  endtask

  task automatic test_random_traffic(logic [dit_pkg::StampWidth-1:0] expire,
                                     int unsigned count);
    int unsigned                    roll;
    int unsigned                    slot;
    logic [dit_pkg::ReqWidth-1:0]   code;
    logic [dit_pkg::IdWidth-1:0]    id;
    logic [dit_pkg::StampWidth-1:0] tnow;
    write_expire(expire);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      slot = $urandom_range(0, TABLE_ENTRIES - 1);
      if ($urandom_range(0, 49) == 0) clock_now = $urandom;
      else clock_now += $urandom_range(0, 40);
      tnow = clock_now;
      if (roll < 45) begin
        code = dit_pkg::REQ_ADD;
        id = ($urandom_range(0, 9) == 0) ? table_ids[slot] : random_id();
      end else if (roll < 80) begin
        code = dit_pkg::REQ_LOOKUP;
        id = ($urandom_range(0, 1) == 0) ? table_ids[slot] : random_id();
      end else if (roll < 95) begin
        code = dit_pkg::REQ_SWEEP;
        id = random_id();
        if (table_ids[slot] != '0 && $urandom_range(0, 1) == 0) begin
          tnow = table_stamps[slot] + expire_setting;
          if ($urandom_range(0, 1) == 0) tnow = tnow - 1'b1;
        end
      end else begin
        code = REQ_UNUSED;
        id = random_id();
        tnow = $urandom;
      end
      send_req(code, id, tnow);
    end
  endtask

  initial begin : drive_rsp_ready
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_responses
    outcome_t want;
    if (!rst && rsp_ch.valid !== 1'b0) begin
      if (rsp_ch.valid !== 1'b1) begin
        note_error("response valid is unknown");
      end else if (rsp_ch.ready) begin
        checked_count++;
        if (pending_outcomes.size() == 0) begin
          note_error($sformatf("response %0d: transfer with no request outstanding",
                               checked_count));
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_ch.found !== want.found) begin
            note_error($sformatf("response %0d: found expected %0b, got %0b",
                                 checked_count, want.found, rsp_ch.found));
          end
          if (rsp_ch.add_failed !== want.add_failed) begin
            note_error($sformatf("response %0d: add_failed expected %0b, got %0b",
                                 checked_count, want.add_failed, rsp_ch.add_failed));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("device_id_table_with_aging_tb: errors");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= dit_pkg::REQ_LOOKUP;
    req_ch.dev_id    <= '0;
    req_ch.now       <= '0;
    foreach (table_ids[i]) begin
      table_ids[i] = '0;
      table_stamps[i] = '0;
    end
    expire_setting = dit_pkg::ExpireReset;
    clock_now = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_add_lookup();
    test_expiry_boundary();
    test_expire_extremes();
    test_random_traffic('0, 300);
    test_random_traffic(TIME_ONES, 350);
    test_random_traffic($urandom_range(1, 200), 350);
    test_random_traffic(32'd1, 300);
    test_random_traffic($urandom, 300);
    idle_en = 1'b0;
    test_random_traffic(dit_pkg::ExpireReset, 350);

    wait_until_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0) begin
      $display("device_id_table_with_aging_tb: clean");
    end else begin
      $display("device_id_table_with_aging_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dit_pkg.sv
hdl/dit_if.sv
hdl/dit_ram.sv
hdl/dit_engine.sv
hdl/device_id_table_with_aging.sv
hdl/dit_checker.sv
test/device_id_table_with_aging_tb.sv
